// File: rtl/running_median_insertion_assert.svh
// Assertion macros for the running median block.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef RUNNING_MEDIAN_INSERTION_ASSERT_SVH
`define RUNNING_MEDIAN_INSERTION_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RMI_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("running_median_insertion: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define RMI_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("running_median_insertion: next-cycle check failed");

`endif

// File: rtl/rmi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rmi_pkg;

	localparam int unsigned SAMPLE_W   = 32;
	localparam int unsigned ORD_W      = 8;
	localparam int unsigned GROUP_SIZE = 16;
	localparam int unsigned GROUP_W    = 4;

	typedef logic signed [SAMPLE_W-1:0] word_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       start_of_set;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] median;
		logic [ORD_W-1:0]           median_number;
		logic                       overflow;
	} out_item_t;

endpackage

`default_nettype wire

// File: rtl/running_median_insertion.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Dir | Handshake                   | Payload
// sample   | in  | sample_valid / sample_stall | sample_item (sample, start_of_set)
// result   | out | result_valid / result_stall | result_item (median, median_number, overflow)
//
// Each item that fits is placed into the sorted row of cells in the cycle it is accepted.
// A result passes lookup stage 1, lookup stage 2 and the output register after the item
// is accepted; the median lookup goes through a registered two-level select over the cells.
// Sustained rate is one item per cycle while the result side does not stall; a stall
// backs up the lookup and then holds sample_stall.
// Reset clears the count, the lookup valids and the output valid; cell contents are
// left as they are and only slots below the count are ever read.
module running_median_insertion #(
	parameter int unsigned CAPACITY = 256
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                sample_valid,
	output logic                     sample_stall,
	input  wire rmi_pkg::in_item_t   sample_item,
	output logic                     result_valid,
	input  wire logic                result_stall,
	output rmi_pkg::out_item_t       result_item
);
	import rmi_pkg::*;

	`include "running_median_insertion_assert.svh"

	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned NG = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
	localparam int unsigned GW = (NG > 1) ? $clog2(NG) : 1;

	// set-level state
	logic [CW-1:0] count_q;
	logic [CW-1:0] eff_count;
	logic          full;
	logic          accept;
	logic          emit;

	// row of cells
	word_t cell_val [CAPACITY];
	logic  cell_gt  [CAPACITY];

	// lookup stage 1: which rank to read
	logic             v_s1;
	logic [IW-1:0]    midx_s1;
	logic [ORD_W-1:0] ord_s1;
	logic             ovf_s1;

	// lookup stage 2: one candidate per group of cells
	logic             v_s2;
	word_t            grp_s2 [NG];
	logic [GW-1:0]    gidx_s2;
	logic [ORD_W-1:0] ord_s2;
	logic             ovf_s2;
	word_t            grp_next [NG];

	// output register
	logic      result_valid_q;
	out_item_t result_q;

	logic adv1;
	logic adv2;

	assign accept    = sample_valid && !sample_stall;
	// a start item empties the set before it is placed
	assign eff_count = sample_item.start_of_set ? '0 : count_q;
	assign full      = eff_count == CW'(CAPACITY);
	// emit after odd-numbered samples, and always on a dropped sample
	assign emit      = full || !eff_count[0];

	// advance the lookup when the next stage frees up
	assign adv2 = v_s2 && (!result_valid_q || !result_stall);
	assign adv1 = v_s1 && (!v_s2 || adv2);
	// hold input while a lookup still has to read the cells as they are now
	assign sample_stall = v_s1 && !adv1;

	// build the cell row; each cell takes its left neighbor's value on a shift
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		word_t prev_val;
		logic  prev_gt;
		if (i == 0) begin : g_head
			assign prev_val = '0;
			assign prev_gt  = 1'b0;
		end else begin : g_link
			assign prev_val = cell_val[i-1];
			assign prev_gt  = cell_gt[i-1];
		end
		rmi_cell #(
			.IDX(i),
			.CW (CW)
		) u_cell (
			.clk      (clk),
			.ins      (accept && !full),
			.eff_count(eff_count),
			.sample   (sample_item.sample),
			.prev_val (prev_val),
			.prev_gt  (prev_gt),
			.val      (cell_val[i]),
			.gt       (cell_gt[i])
		);
	end

	// count of samples held in the current set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			if (full) begin
				count_q <= eff_count;
			end else begin
				count_q <= eff_count + CW'(1);
			end
		end
	end

	// stage 1: median rank is half the count before insertion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= emit;
		end else if (adv1) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			midx_s1 <= IW'(eff_count >> 1);
			ord_s1  <= ORD_W'({1'b0, eff_count} >> 1) + ORD_W'(1);
			ovf_s1  <= full;
		end
	end

	// OR together the selected slot of each group; at most one slot matches
	always_comb begin
		for (int g = 0; g < NG; g++) begin
			grp_next[g] = '0;
			for (int k = 0; k < GROUP_SIZE; k++) begin
				if (g * GROUP_SIZE + k < CAPACITY) begin
					if (midx_s1 == IW'(g * GROUP_SIZE + k)) begin
						grp_next[g] = grp_next[g] | cell_val[g * GROUP_SIZE + k];
					end
				end
			end
		end
	end

	// stage 2: group candidates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv1) begin
			v_s2 <= 1'b1;
		end else if (adv2) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			grp_s2  <= grp_next;
			gidx_s2 <= GW'(midx_s1 >> GROUP_W);
			ord_s2  <= ord_s1;
			ovf_s2  <= ovf_s1;
		end
	end

	// output register: pick the group, zero the fields on a dropped sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv2) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			result_q.median        <= ovf_s2 ? '0 : grp_s2[gidx_s2];
			result_q.median_number <= ovf_s2 ? '0 : ord_s2;
			result_q.overflow      <= ovf_s2;
		end
	end

	assign result_valid = result_valid_q;
	assign result_item  = result_q;

	`RMI_ASSERT_SAME(a_count_bound, 1'b1, count_q <= CW'(CAPACITY))
	`RMI_ASSERT_SAME(a_stall_cause, sample_stall, v_s1 && v_s2 && result_valid_q && result_stall)
	`RMI_ASSERT_NEXT(a_full_drops, accept && !sample_item.start_of_set && count_q == CW'(CAPACITY), v_s1 && ovf_s1 && count_q == CW'(CAPACITY))
	`RMI_ASSERT_NEXT(a_start_counts_one, accept && sample_item.start_of_set, count_q == CW'(1) && v_s1 && !ovf_s1)

endmodule

`default_nettype wire

// File: rtl/rmi_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One slot of the sorted row. Slot IDX holds the element of rank IDX.
module rmi_cell #(
	parameter int unsigned IDX = 0,
	parameter int unsigned CW  = 9
) (
	input  wire logic            clk,
	input  wire logic            ins,
	input  wire logic [CW-1:0]   eff_count,
	input  wire rmi_pkg::word_t  sample,
	input  wire rmi_pkg::word_t  prev_val,
	input  wire logic            prev_gt,
	output rmi_pkg::word_t       val,
	output logic                 gt
);
	import rmi_pkg::*;

	logic  occ;
	logic  at_end;
	word_t val_q;

	assign occ    = eff_count > CW'(IDX);
	assign at_end = eff_count == CW'(IDX);
	// strictly greater: equal values stay ahead of the new sample
	assign gt     = occ && (val_q > sample);
	assign val    = val_q;

	always_ff @(posedge clk) begin
		if (ins) begin
			if (prev_gt) begin
				val_q <= prev_val;
			end else if (gt || at_end) begin
				val_q <= sample;
			end
		end
	end

endmodule

`default_nettype wire

// File: tb/running_median_insertion_checker.sv
`timescale 1ns / 1ps

// Watches both channels, keeps a sorted copy of the current set, and checks
// each result against the oldest median still owed.
module running_median_insertion_checker #(
	parameter int unsigned CAPACITY = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	input  logic               sample_stall,
	input  rmi_pkg::in_item_t  sample_item,
	input  logic               result_valid,
	input  logic               result_stall,
	input  rmi_pkg::out_item_t result_item,
	output int unsigned        mismatches,
	output int unsigned        outstanding
);
	import rmi_pkg::*;

	word_t       sorted_vals [CAPACITY];
	int unsigned set_count;
	out_item_t   medians_due [$];
	out_item_t   want;

	// Insert after equals; owe a median on odd counts, an overflow when full.
	task automatic insert_and_take_median(input in_item_t it);
		out_item_t   m;
		word_t       v;
		int unsigned pos;
		v = it.sample;
		m = '0;
		if (it.start_of_set)
			set_count = 0;
		if (set_count >= CAPACITY) begin
			m.overflow = 1'b1;
			medians_due.push_back(m);
			return;
		end
		pos = set_count;
		while (pos > 0 && sorted_vals[pos-1] > v) begin
			sorted_vals[pos] = sorted_vals[pos-1];
			pos--;
		end
		sorted_vals[pos] = v;
		set_count++;
		if (set_count % 2 == 1) begin
			m.median        = sorted_vals[(set_count - 1) / 2];
			m.median_number = ORD_W'((set_count + 1) / 2);
			medians_due.push_back(m);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_count  = 0;
			mismatches = 0;
			medians_due.delete();
		end else begin
			if (result_valid && !result_stall) begin
				if (medians_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: median %0d number %0d overflow %0b",
							result_item.median, result_item.median_number,
							result_item.overflow);
				end else begin
					want = medians_due.pop_front();
					if (result_item.median !== want.median ||
					    result_item.median_number !== want.median_number ||
					    result_item.overflow !== want.overflow) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"result mismatch: expected median %0d number %0d ",
								"overflow %0b, got median %0d number %0d overflow %0b"},
								want.median, want.median_number, want.overflow,
								result_item.median, result_item.median_number,
								result_item.overflow);
					end
				end
			end
			if (sample_valid && !sample_stall)
				insert_and_take_median(sample_item);
		end
		outstanding = medians_due.size();
	end

endmodule

// File: tb/running_median_insertion_tb.sv
`timescale 1ns / 1ps

module running_median_insertion_tb;
	import rmi_pkg::*;

	localparam int unsigned CAPACITY     = 256;
	localparam int unsigned ITEM_TARGET  = 1250;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned LONG_HOLD    = 300;
	localparam int unsigned DRAIN_CYCLES = 12;
	localparam word_t       WORD_MIN     = 32'h8000_0000;
	localparam word_t       WORD_MAX     = 32'h7FFF_FFFF;

	logic        clk;
	logic        arst_n;
	logic        sample_valid;
	logic        sample_stall;
	in_item_t    sample_item;
	logic        result_valid;
	logic        result_stall;
	out_item_t   result_item;

	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned cycles;
	int unsigned items_sent;

	// Idle odds in percent, changed per phase by the stimulus process.
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;

	// Long receiver hold-offs: stimulus requests them, the receiver counts them out.
	int unsigned hold_requests;
	int unsigned holds_done;
	int unsigned hold_left;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	running_median_insertion #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample_item (sample_item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_item (result_item)
	);

	running_median_insertion_checker #(
		.CAPACITY(CAPACITY)
	) median_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample_item (sample_item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_item (result_item),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// Guard against a hung handshake or a median that never shows up.
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("[running_median_insertion] ERROR");
			$finish;
		end
	end

	// Receiver: random stalls, or a long hold-off when one is requested so the
	// lookup backs up and the block has to stall its input.
	initial begin
		result_stall = 1'b0;
		holds_done   = 0;
		hold_left    = 0;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && holds_done != hold_requests) begin
				hold_left = LONG_HOLD;
				holds_done++;
			end
			if (hold_left != 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// Mix full-range words, a narrow band around zero (lots of equal values)
	// and the signed extremes.
	function automatic word_t pick_value();
		case ($urandom_range(9))
			0, 1, 2, 3: return $urandom;
			4, 5, 6, 7: return $urandom_range(16) - 8;
			default: begin
				case ($urandom_range(3))
					0: return WORD_MIN;
					1: return WORD_MAX;
					2: return '0;
					default: return '1;
				endcase
			end
		endcase
	endfunction

	// Offer one item, idling first at the current odds; return once accepted.
	// Valid stays high into the next item unless an idle cycle lowers it.
	task automatic offer_item(input word_t v, input logic first);
		in_item_t it;
		while ($urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		it.sample       = v;
		it.start_of_set = first;
		sample_item  <= it;
		sample_valid <= 1'b1;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		items_sent++;
	endtask

	// One set of random content; with restarts allowed, a stray start flag
	// now and then breaks the set early.
	task automatic offer_set(input int unsigned len, input bit restarts);
		for (int unsigned i = 0; i < len; i++)
			offer_item(pick_value(), i == 0 || (restarts && $urandom_range(99) < 2));
	endtask

	initial begin
		arst_n         = 1'b0;
		sample_valid   = 1'b0;
		sample_item    = '0;
		cycles         = 0;
		items_sent     = 0;
		hold_requests  = 0;
		send_idle_pct  = 34;
		recv_stall_pct = 56;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extremes and zero in one set; equal values land after their equals.
		offer_item('0, 1'b1);
		offer_item(WORD_MIN, 1'b0);
		offer_item(WORD_MAX, 1'b0);
		offer_item('1, 1'b0);
		offer_item('1, 1'b0);
		// Back-to-back starts: each one empties the store.
		offer_item(WORD_MAX, 1'b1);
		offer_item(WORD_MIN, 1'b1);
		offer_item(WORD_MIN, 1'b0);
		offer_item(WORD_MIN, 1'b0);
		offer_item(32'sd5, 1'b0);
		offer_item(32'sd5, 1'b0);
		offer_item(32'sd7, 1'b0);
		offer_item(32'sd7, 1'b0);
		// Descending arrivals push every new sample to the bottom.
		offer_item(32'sd100, 1'b1);
		offer_item(32'sd50, 1'b0);
		offer_item(32'sd25, 1'b0);
		offer_item(32'sd12, 1'b0);
		offer_item(32'sd6, 1'b0);
		// Alternating bit patterns, both signs.
		offer_item(32'h5555_5555, 1'b1);
		offer_item(32'hAAAA_AAAA, 1'b0);
		offer_item(32'h0F0F_0F0F, 1'b0);
		offer_item(32'hF0F0_F0F0, 1'b0);

		// Three idle regimes; each later phase opens with a full set that runs
		// past capacity so the overflow results show up, and the last phase
		// also holds the receiver off for a long stretch.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct  = 34;
					recv_stall_pct = 56;
				end
				1: begin
					send_idle_pct  = 56;
					recv_stall_pct = 34;
				end
				default: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
					hold_requests++;
				end
			endcase
			if (phase != 0)
				offer_set(CAPACITY + $urandom_range(1, 6), 1'b0);
			while (items_sent < (phase + 1) * ITEM_TARGET / 3)
				offer_set($urandom_range(1, 40), 1'b1);
		end
		sample_valid <= 1'b0;

		// Drain: wait until every owed median has come, then watch for strays.
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0) begin
			$display("[running_median_insertion] OK");
		end else begin
			$display("[running_median_insertion] ERROR");
		end
		$finish;
	end

endmodule
